@@ rtl/core/knap_pkg.sv @@
// Shared types and constants for the knapsack exhaustive-search block.
// Used by knap_store and knapsack_exhaustive_search_top; no dependencies.
`default_nettype none

package knap_pkg;

    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned CAP_W    = 20;
    localparam int unsigned TOTAL_W  = 20;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 56;

    typedef struct packed {
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] weight;
        logic [FIELD_W-1:0] price;
    } t_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_PREP,
        ST_SCAN,
        ST_EMIT,
        ST_NONE
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/knap_store.sv @@
// Item store: one write port, one registered read port.
// Depends on knap_pkg (t_item).
`default_nettype none

module knap_store #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire knap_pkg::t_item                         i_wr_item,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output knap_pkg::t_item                              o_rd_item
);
    import knap_pkg::*;

    t_item r_mem [DEPTH];
    t_item r_rd_item;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_item;
        end
        r_rd_item <= r_mem[i_rd_addr];
    end

    assign o_rd_item = r_rd_item;

endmodule

`default_nettype wire

@@ rtl/core/knapsack_exhaustive_search_top.sv @@
// 0/1 knapsack by exhaustive Gray-code search; depends on knap_pkg and knap_store.
// Load: one item per cycle. After the last item, the search steps through every subset of the n
// stored items, one subset per cycle through the shared add/sub unit, then a prep state.
// Emit: the scan skips unchosen items and sends each chosen item once the output is free; an
// empty subset sends one empty marker. Input not ready from the last item to the last result.
// Reset is synchronous, active low: control state and capacity cleared to 0.
`default_nettype none

module knapsack_exhaustive_search_top #(
    parameter int unsigned MAX_ITEMS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [knap_pkg::CAP_W-1:0]     i_cfg_wdata,   // capacity
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [knap_pkg::S_DATA_W-1:0]  i_s_tdata,     // item_id, item_weight, item_price
    input  wire logic                           i_s_tlast,     // last_item
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [knap_pkg::M_DATA_W-1:0]       o_m_tdata,     // chosen_id, chosen_weight,
                                                               // total_price, zero pad
    output logic                                o_m_tuser,     // none_chosen
    output logic                                o_m_tlast      // last_result
);
    import knap_pkg::*;

    localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int unsigned SUB_W = MAX_ITEMS + 1;
    localparam int unsigned SUM_W = FIELD_W + CNT_W;
    localparam int unsigned CMP_W = (SUM_W > CAP_W) ? SUM_W : CAP_W;
    localparam int unsigned PAD_W = M_DATA_W - 2 * FIELD_W - TOTAL_W;
    localparam logic [CMP_W-1:0] PRICE_SAT = CMP_W'((64'd1 << TOTAL_W) - 64'd1);

    t_state                 r_state, n_state;
    logic [CAP_W-1:0]       r_cap;
    logic [CNT_W-1:0]       r_count;
    logic [SUB_W-1:0]       r_i;
    logic [MAX_ITEMS-1:0]   r_gray;
    logic                   r_a_valid, r_a_add;
    logic [MAX_ITEMS-1:0]   r_a_mask;
    logic                   r_b_valid;
    logic [MAX_ITEMS-1:0]   r_b_mask;
    logic [SUM_W-1:0]       r_wsum, r_psum;
    logic [SUM_W-1:0]       r_best_price;
    logic [MAX_ITEMS-1:0]   r_best_mask;
    logic [MAX_ITEMS-1:0]   r_sel;
    logic [CNT_W-1:0]       r_j;
    logic                   r_o_valid;
    logic [FIELD_W-1:0]     r_o_id, r_o_weight;
    logic [TOTAL_W-1:0]     r_o_total;
    logic                   r_o_none, r_o_last;

    logic                   s_accept, st_wr_en, issue, search_done, out_free;
    logic                   fits, better, update;
    logic                   emit_load, none_load, scan_skip, scan_end;
    logic [CNT_W-1:0]       count_plus, flip_b, flip_item;
    logic [SUB_W-1:0]       total_subsets;
    logic [MAX_ITEMS-1:0]   flip_onehot, new_gray, sel_rest;
    logic                   sel_last;
    logic [IDX_W-1:0]       rd_addr;
    logic [CMP_W-1:0]       best_cmp;
    logic [TOTAL_W-1:0]     total_sat;
    t_item                  wr_item, rd_item;

    knap_store #(
        .DEPTH(MAX_ITEMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_item (wr_item),
        .i_rd_addr (rd_addr),
        .o_rd_item (rd_item)
    );

    assign wr_item.id     = i_s_tdata[FIELD_W-1:0];
    assign wr_item.weight = i_s_tdata[2*FIELD_W-1:FIELD_W];
    assign wr_item.price  = i_s_tdata[3*FIELD_W-1:2*FIELD_W];

    assign o_s_tready = (r_state == ST_LOAD);
    assign s_accept   = i_s_tvalid & o_s_tready;
    assign st_wr_en   = s_accept && (r_count < CNT_W'(MAX_ITEMS));
    assign count_plus = st_wr_en ? r_count + CNT_W'(1) : r_count;

    assign total_subsets = SUB_W'(1) << r_count;
    assign issue         = (r_state == ST_SEARCH) && (r_i != total_subsets);
    assign search_done   = (r_state == ST_SEARCH) && !issue && !r_a_valid && !r_b_valid;

    // lowest set bit of the counter is the Gray bit that flips
    always_comb begin
        flip_b = '0;
        for (int k = SUB_W - 1; k >= 0; k--) begin
            if (r_i[k]) begin
                flip_b = CNT_W'(k);
            end
        end
    end

    assign flip_item   = r_count - CNT_W'(1) - flip_b;
    assign flip_onehot = MAX_ITEMS'(1) << flip_b;
    assign new_gray    = r_gray ^ flip_onehot;
    assign rd_addr     = (r_state == ST_SEARCH) ? flip_item[IDX_W-1:0] : r_j[IDX_W-1:0];

    assign fits   = (CMP_W'(r_wsum) <= CMP_W'(r_cap));
    assign better = (r_psum > r_best_price) ||
                    ((r_psum == r_best_price) && (r_b_mask < r_best_mask));
    assign update = r_b_valid && fits && better;

    assign out_free = !r_o_valid || i_m_tready;
    assign sel_rest = r_sel << 1;
    assign sel_last = (sel_rest == '0);

    assign best_cmp  = CMP_W'(r_best_price);
    assign total_sat = (best_cmp > PRICE_SAT) ? PRICE_SAT[TOTAL_W-1:0] : best_cmp[TOTAL_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (s_accept && i_s_tlast) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (search_done) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = (r_best_mask == '0) ? ST_NONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (r_j == r_count) begin
                    n_state = ST_LOAD;
                end else if (r_sel[MAX_ITEMS-1]) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = sel_last ? ST_LOAD : ST_SCAN;
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        emit_load = 1'b0;
        none_load = 1'b0;
        scan_skip = 1'b0;
        scan_end  = 1'b0;
        case (r_state)
            ST_SCAN: begin
                scan_end  = (r_j == r_count);
                scan_skip = (r_j != r_count) && !r_sel[MAX_ITEMS-1];
            end
            ST_EMIT: begin
                emit_load = out_free;
            end
            ST_NONE: begin
                none_load = out_free;
            end
            default: begin
                emit_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_cap        <= '0;
            r_count      <= '0;
            r_i          <= '0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_best_price <= '0;
            r_best_mask  <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end

            if (s_accept) begin
                r_count <= count_plus;
                if (i_s_tlast) begin
                    r_i          <= SUB_W'(1);
                    r_gray       <= '0;
                    r_wsum       <= '0;
                    r_psum       <= '0;
                    r_best_price <= '0;
                    r_best_mask  <= '0;
                end
            end

            // stage A: pick the flipped item, read it
            r_a_valid <= issue;
            if (issue) begin
                r_i      <= r_i + SUB_W'(1);
                r_gray   <= new_gray;
                r_a_add  <= |(new_gray & flip_onehot);
                r_a_mask <= new_gray;
            end

            // stage B: shared add/sub on the running sums
            r_b_valid <= r_a_valid;
            if (r_a_valid) begin
                r_b_mask <= r_a_mask;
                if (r_a_add) begin
                    r_wsum <= r_wsum + SUM_W'(rd_item.weight);
                    r_psum <= r_psum + SUM_W'(rd_item.price);
                end else begin
                    r_wsum <= r_wsum - SUM_W'(rd_item.weight);
                    r_psum <= r_psum - SUM_W'(rd_item.price);
                end
            end

            // stage C: keep the best fitting subset
            if (update) begin
                r_best_price <= r_psum;
                r_best_mask  <= r_b_mask;
            end

            if (r_state == ST_PREP) begin
                r_sel <= r_best_mask << (CNT_W'(MAX_ITEMS) - r_count);
                r_j   <= '0;
            end

            if (scan_skip) begin
                r_sel <= sel_rest;
                r_j   <= r_j + CNT_W'(1);
            end

            if (emit_load) begin
                r_o_id     <= rd_item.id;
                r_o_weight <= rd_item.weight;
                r_o_total  <= total_sat;
                r_o_none   <= 1'b0;
                r_o_last   <= sel_last;
                r_sel      <= sel_rest;
                r_j        <= r_j + CNT_W'(1);
            end

            if (none_load) begin
                r_o_id     <= '0;
                r_o_weight <= '0;
                r_o_total  <= '0;
                r_o_none   <= 1'b1;
                r_o_last   <= 1'b1;
            end

            if (scan_end || none_load || (emit_load && sel_last)) begin
                r_count <= '0;
            end

            if (emit_load || none_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_o_total, r_o_weight, r_o_id};
    assign o_m_tuser  = r_o_none;
    assign o_m_tlast  = r_o_last;

endmodule

`default_nettype wire
